@@ hw/rtl/wrms_pkg.sv @@
// ----------------------------------------------------------------------------
// wrms_pkg
// shared sizes, accumulator record layout and memory control bundle for the
// rms / offset / peak meter
// ----------------------------------------------------------------------------
package wrms_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int PHASES      = 3;
    localparam int PHASE_W     = 2;
    localparam int MAX_SAMPLES = 65536;

    // sample and clip counters must hold MAX_SAMPLES itself
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = 33;
    localparam int SQ_W  = 47;
    localparam int THR_W = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd20794;

    // divider: dividend as wide as the square sum, divisor is a sample count
    localparam int DIV_W      = SQ_W;
    localparam int DIV_STEP_W = $clog2(DIV_W + 1);

    // square root: even-width radicand, one root bit per step
    localparam int RT_IN_W   = 48;
    localparam int RT_W      = RT_IN_W / 2;
    localparam int RT_STEP_W = $clog2(RT_W + 1);

    typedef struct packed {
        logic                          ovf;
        logic [CNT_W-1:0]              cnt;
        logic [CNT_W-1:0]              clip;
        logic signed [SAMPLE_BITS-1:0] max_v;
        logic signed [SAMPLE_BITS-1:0] min_v;
        logic signed [SUM_W-1:0]       sum;
        logic [SQ_W-1:0]               sq;
    } t_acc;

    typedef struct packed {
        logic               rd_en;
        logic [PHASE_W-1:0] rd_addr;
        logic               wr_en;
        logic               clr_en;
        logic [PHASE_W-1:0] wr_addr;
    } t_mem_ctl;

endpackage

@@ hw/rtl/wrms_acc_mem.sv @@
// ----------------------------------------------------------------------------
// wrms_acc_mem
// per-phase accumulator memory, registered read, valid bit per entry so a
// cleared or never written entry reads as an empty record
// ----------------------------------------------------------------------------
module wrms_acc_mem
    import wrms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_ctl i_ctl,
    input  t_acc     i_wr_data,
    output t_acc     o_rd_data
);

    t_acc              r_mem [PHASES];
    logic [PHASES-1:0] r_valid;
    t_acc              r_rd_data;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b1;
            end else if (i_ctl.clr_en) begin
                r_valid[i_ctl.wr_addr] <= 1'b0;
            end
            if (i_ctl.rd_en) begin
                r_rd_valid <= r_valid[i_ctl.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ hw/rtl/wrms_div.sv @@
// ----------------------------------------------------------------------------
// wrms_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wrms_div
    import wrms_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_dsr;
    logic [DIV_W-1:0]      r_acc;

    logic [CNT_W:0] rem_sh;
    logic [CNT_W:0] diff;
    logic           ge;

    // remainder stays below the divisor, so the shifted value fits one more bit
    assign rem_sh = {r_rem, r_acc[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, r_dsr};
    assign diff   = rem_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= DIV_STEP_W'(DIV_W);
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_acc <= i_dividend;
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_STEP_W'(1);
            r_rem <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_acc <= {r_acc[DIV_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_acc;

endmodule

@@ hw/rtl/wrms_sqrt.sv @@
// ----------------------------------------------------------------------------
// wrms_sqrt
// floor integer square root, digit by digit, one root bit per cycle
// ----------------------------------------------------------------------------
module wrms_sqrt
    import wrms_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [RT_IN_W-1:0] i_radicand,
    output logic               o_done,
    output logic [RT_W-1:0]    o_root
);

    logic                 r_busy;
    logic                 r_done;
    logic [RT_STEP_W-1:0] r_cnt;
    logic [RT_IN_W-1:0]   r_x;
    logic [RT_W+1:0]      r_rem;
    logic [RT_W-1:0]      r_root;

    logic [RT_W+1:0] rem_sh;
    logic [RT_W+1:0] trial;
    logic            ge;

    // partial remainder never exceeds twice the partial root, so its low
    // RT_W bits carry it before the shift
    assign rem_sh = {r_rem[RT_W-1:0], r_x[RT_IN_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == RT_STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= RT_STEP_W'(RT_W);
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - RT_STEP_W'(1);
            r_x    <= {r_x[RT_IN_W-3:0], 2'b00};
            r_rem  <= ge ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[RT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ hw/rtl/waveform_rms_offset_peak_stats_core.sv @@
// ----------------------------------------------------------------------------
// waveform_rms_offset_peak_stats_core
// three-phase waveform meter: rms, mean offset, peak-to-peak and clip count
// ----------------------------------------------------------------------------
// a sample without the last mark blocks the input while its record is modified
//   and written back; an unused phase code is taken without blocking the input
// a last sample shows its result after two 47-step passes of the shared divider,
//   the 24-step root runs under the second one
// no new sample is taken until the last one is written back or its record is handed on
// reset (synchronous, active low) empties all records, loads the default threshold
// ----------------------------------------------------------------------------
module waveform_rms_offset_peak_stats_core
    import wrms_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    // configuration: clip threshold
    input  logic                          i_cfg_wr_en,
    input  logic [THR_W-1:0]              i_cfg_wr_data,

    // sample items
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [PHASE_W-1:0]            i_phase,
    input  logic                          i_last_sample,

    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [PHASE_W-1:0]            o_result_phase,
    output logic [SAMPLE_BITS-1:0]        o_rms_value,
    output logic signed [SAMPLE_BITS-1:0] o_offset_value,
    output logic [SAMPLE_BITS-1:0]        o_peak_to_peak,
    output logic [CNT_W-1:0]              o_clip_count,
    output logic                          o_overflow
);

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;  // waiting for a sample
    localparam logic [2:0] S_UPD      = 3'd1;  // read data back, modify, write
    localparam logic [2:0] S_SQ_GO    = 3'd2;  // launch square sum / n
    localparam logic [2:0] S_SQ_WAIT  = 3'd3;
    localparam logic [2:0] S_SUM_GO   = 3'd4;  // launch |sum| / n and the root
    localparam logic [2:0] S_SUM_WAIT = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;  // hand off to the output register

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic [THR_W-1:0] r_thr;

    // item being worked on
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [PHASE_W-1:0]            r_phase;
    logic                          r_last;

    // closed record, waiting for the divide and root
    logic [CNT_W-1:0]       r_n;
    logic [SUM_W-1:0]       r_sum_mag;
    logic                   r_sum_neg;
    logic [SQ_W-1:0]        r_sq;
    logic [SAMPLE_BITS-1:0] r_p2p;
    logic [CNT_W-1:0]       r_clip;
    logic                   r_ovf;
    logic [DIV_W-1:0]       r_ms;
    logic [SAMPLE_BITS-1:0] r_mean;
    logic [SAMPLE_BITS-1:0] r_rms;

    // output register
    logic                   r_out_valid;
    logic [PHASE_W-1:0]     r_out_phase;
    logic [SAMPLE_BITS-1:0] r_out_rms;
    logic [SAMPLE_BITS-1:0] r_out_mean;
    logic [SAMPLE_BITS-1:0] r_out_p2p;
    logic [CNT_W-1:0]       r_out_clip;
    logic                   r_out_ovf;

    logic       in_acc;
    logic       phase_ok;
    logic       out_load;
    t_mem_ctl   mem_ctl;
    t_acc       rd_acc;
    t_acc       nx_acc;

    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] sq_term;
    logic                     full;
    logic                     first;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;
    logic             rt_start;
    logic             rt_done;
    logic [RT_W-1:0]  rt_root;

    // ------------------------------------------------------------------
    // input handshake: only the idle state takes a sample; an unused phase
    // code is taken and dropped without touching the memory
    // ------------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign phase_ok   = (i_phase < PHASE_W'(PHASES));

    // the output register is free when empty or being taken this cycle
    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // ------------------------------------------------------------------
    // accumulator memory: read on accept, written back (or cleared when the record closes) in the next cycle.
    // the sequencer holds off the next sample until the write is done, so a
    // read never sees a stale entry of the same phase
    // ------------------------------------------------------------------
    always_comb begin
        mem_ctl.rd_en   = in_acc && phase_ok;
        mem_ctl.rd_addr = i_phase;
        mem_ctl.wr_en   = (r_state == S_UPD) && !r_last;
        mem_ctl.clr_en  = (r_state == S_UPD) && r_last;   // record closes
        mem_ctl.wr_addr = r_phase;
    end

    wrms_acc_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_wr_data (nx_acc),
        .o_rd_data (rd_acc)
    );

    // ------------------------------------------------------------------
    // record update
    // ------------------------------------------------------------------
    // magnitude of the most negative sample still fits unsigned
    assign mag     = r_sample[SAMPLE_BITS-1] ? (~r_sample + SAMPLE_BITS'(1)) : r_sample;
    assign sq_term = mag * mag;
    assign full    = (rd_acc.cnt >= CNT_W'(MAX_SAMPLES));
    assign first   = (rd_acc.cnt == '0);

    always_comb begin
        nx_acc = rd_acc;
        if (full) begin
            // record too long: sample dropped, flag kept until the record ends
            nx_acc.ovf = 1'b1;
        end else begin
            // min and max start from the first sample of a record
            if (first || (r_sample < rd_acc.min_v)) begin
                nx_acc.min_v = r_sample;
            end
            if (first || (r_sample > rd_acc.max_v)) begin
                nx_acc.max_v = r_sample;
            end
            if (mag >= r_thr) begin
                nx_acc.clip = rd_acc.clip + CNT_W'(1);
            end
            nx_acc.sum = rd_acc.sum + SUM_W'(r_sample);
            nx_acc.sq  = rd_acc.sq + SQ_W'(sq_term);
            nx_acc.cnt = rd_acc.cnt + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // shared divider (square sum first, then sum magnitude) and square root
    // ------------------------------------------------------------------
    assign div_start    = (r_state == S_SQ_GO) || (r_state == S_SUM_GO);
    assign div_dividend = (r_state == S_SQ_GO) ? r_sq
                                               : {{(DIV_W-SUM_W){1'b0}}, r_sum_mag};
    // the mean square is ready once the first pass is done
    assign rt_start     = (r_state == S_SUM_GO);

    wrms_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_n),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    wrms_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rt_start),
        .i_radicand ({{(RT_IN_W-DIV_W){1'b0}}, r_ms}),
        .o_done     (rt_done),
        .o_root     (rt_root)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && phase_ok) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = r_last ? S_SQ_GO : S_IDLE;
            end
            S_SQ_GO: begin
                n_state = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (div_done) begin
                    n_state = S_SUM_GO;
                end
            end
            S_SUM_GO: begin
                n_state = S_SUM_WAIT;
            end
            S_SUM_WAIT: begin
                // the root is shorter than a divide pass and is done by now
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_sample;
            r_phase  <= i_phase;
            r_last   <= i_last_sample;
        end

        // capture the closing record; the count is never zero here
        if ((r_state == S_UPD) && r_last) begin
            r_n       <= nx_acc.cnt;
            r_sum_neg <= nx_acc.sum[SUM_W-1];
            r_sum_mag <= nx_acc.sum[SUM_W-1] ? (~nx_acc.sum + SUM_W'(1)) : nx_acc.sum;
            r_sq      <= nx_acc.sq;
            r_p2p     <= nx_acc.max_v - nx_acc.min_v;
            r_clip    <= nx_acc.clip;
            r_ovf     <= nx_acc.ovf;
        end

        if ((r_state == S_SQ_WAIT) && div_done) begin
            r_ms <= div_quot;
        end

        // mean truncates toward zero: divide the magnitude, restore the sign
        if ((r_state == S_SUM_WAIT) && div_done) begin
            r_mean <= r_sum_neg ? (~div_quot[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                                : div_quot[SAMPLE_BITS-1:0];
        end

        if (rt_done) begin
            r_rms <= rt_root[SAMPLE_BITS-1:0];
        end

        if (out_load) begin
            r_out_phase <= r_phase;
            r_out_rms   <= r_rms;
            r_out_mean  <= r_mean;
            r_out_p2p   <= r_p2p;
            r_out_clip  <= r_clip;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_phase = r_out_phase;
    assign o_rms_value    = r_out_rms;
    assign o_offset_value = r_out_mean;
    assign o_peak_to_peak = r_out_p2p;
    assign o_clip_count   = r_out_clip;
    assign o_overflow     = r_out_ovf;

endmodule

@@ hw/rtl/wrms_checker.sv @@
// ----------------------------------------------------------------------------
// wrms_checker
// port-level checks for the meter, bound to the top level
// ----------------------------------------------------------------------------
module wrms_checker
    import wrms_pkg::*;
(
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic [PHASE_W-1:0]            i_phase,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [PHASE_W-1:0]            o_result_phase,
    input logic [SAMPLE_BITS-1:0]        o_rms_value,
    input logic signed [SAMPLE_BITS-1:0] o_offset_value,
    input logic [SAMPLE_BITS-1:0]        o_peak_to_peak,
    input logic [CNT_W-1:0]              o_clip_count,
    input logic                          o_overflow
);

    // a held result keeps its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_phase)
            && $stable(o_rms_value) && $stable(o_offset_value)
            && $stable(o_peak_to_peak) && $stable(o_clip_count) && $stable(o_overflow))
        else $error("result changed while stalled");

    // reset drops any pending result
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

    // a sample of a used phase blocks the input for its write-back cycle
    a_upd_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_phase < PHASE_W'(PHASES)) |=> o_in_stall)
        else $error("input open during record update");

    // an unused phase code is dropped without blocking the input
    a_bad_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_phase >= PHASE_W'(PHASES)) |=> !o_in_stall)
        else $error("unused phase started work");

    // only phases that exist report
    a_res_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result_phase < PHASE_W'(PHASES)))
        else $error("result for unused phase");

endmodule

bind waveform_rms_offset_peak_stats_core wrms_checker u_wrms_checker (.*);

@@ dv/tb_waveform_rms_offset_peak_stats_core.sv @@
// ----------------------------------------------------------------------------
// tb_waveform_rms_offset_peak_stats_core
// self-checking bench for the three-phase rms / offset / peak meter: samples
// go in through a queue-fed driver, a local meter model predicts every record
// report, and a monitor compares each report field by field in order
// ----------------------------------------------------------------------------
module tb_waveform_rms_offset_peak_stats_core;
    import wrms_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RST_CYCLES = 9;
    // unused phase code, dropped by the block without a trace
    localparam logic [PHASE_W-1:0] PH_UNUSED = PHASE_W'(PHASES);
    // time for non-last samples to finish after acceptance, with margin
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 300_000;

    // one sample item as the driver presents it
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic [PHASE_W-1:0]            ph;
        logic                          last;
    } t_sample_item;

    // one record report
    typedef struct {
        logic [PHASE_W-1:0]            ph;
        logic [SAMPLE_BITS-1:0]        rms;
        logic signed [SAMPLE_BITS-1:0] offs;
        logic [SAMPLE_BITS-1:0]        p2p;
        logic [CNT_W-1:0]              clips;
        logic                          ovf;
    } t_report;

    // dut connections, inputs all known from time zero
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [THR_W-1:0]              cfg_wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [SAMPLE_BITS-1:0] in_sample = '0;
    logic [PHASE_W-1:0]            in_phase = '0;
    logic                          in_last = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [PHASE_W-1:0]            out_phase;
    logic [SAMPLE_BITS-1:0]        out_rms;
    logic signed [SAMPLE_BITS-1:0] out_offset;
    logic [SAMPLE_BITS-1:0]        out_p2p;
    logic [CNT_W-1:0]              out_clips;
    logic                          out_ovf;

    // stimulus and checking state
    t_sample_item pending_samples[$];
    t_report      expected_reports[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           err_count = 0;
    logic [THR_W-1:0] cur_thr = THR_RESET;
    t_sample_item drv_item;

    // meter model state, one accumulator set per phase
    logic [THR_W-1:0]              thr_model;
    logic signed [SUM_W-1:0]       acc_sum  [PHASES];
    logic [SQ_W-1:0]               acc_sq   [PHASES];
    logic signed [SAMPLE_BITS-1:0] acc_min  [PHASES];
    logic signed [SAMPLE_BITS-1:0] acc_max  [PHASES];
    logic [CNT_W-1:0]              acc_clips[PHASES];
    logic [CNT_W-1:0]              acc_cnt  [PHASES];
    logic                          acc_ovf  [PHASES];

    waveform_rms_offset_peak_stats_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_sample       (in_sample),
        .i_phase        (in_phase),
        .i_last_sample  (in_last),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_phase (out_phase),
        .o_rms_value    (out_rms),
        .o_offset_value (out_offset),
        .o_peak_to_peak (out_p2p),
        .o_clip_count   (out_clips),
        .o_overflow     (out_ovf)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // meter model
    // ------------------------------------------------------------------------

    // floor square root, one root bit decided per step from the top
    function automatic logic [SAMPLE_BITS-1:0] floor_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) root = trial;
        end
        return root[SAMPLE_BITS-1:0];
    endfunction

    function automatic void clear_phase_acc(int p);
        acc_sum[p]   = '0;
        acc_sq[p]    = '0;
        acc_min[p]   = '0;
        acc_max[p]   = '0;
        acc_clips[p] = '0;
        acc_cnt[p]   = '0;
        acc_ovf[p]   = 1'b0;
    endfunction

    // fold one accepted sample into its phase, queue a report on a last mark
    function automatic void meter_accept(t_sample_item it);
        int              p;
        int              sv;
        int              mag;
        longint          mean_q;
        longint unsigned mean_sq;
        t_report         rep;
        if (it.ph >= PHASES) return;
        p  = it.ph;
        sv = it.smp;
        if (acc_cnt[p] >= MAX_SAMPLES) begin
            // record full: sample dropped, flag kept until the report
            acc_ovf[p] = 1'b1;
        end else begin
            mag = (sv < 0) ? -sv : sv;
            // min and max start from the first sample of the record
            if (acc_cnt[p] == 0) begin
                acc_min[p] = it.smp;
                acc_max[p] = it.smp;
            end else begin
                if (it.smp < acc_min[p]) acc_min[p] = it.smp;
                if (it.smp > acc_max[p]) acc_max[p] = it.smp;
            end
            if (mag >= int'(thr_model)) acc_clips[p] = acc_clips[p] + 1'b1;
            acc_sum[p] = acc_sum[p] + it.smp;
            acc_sq[p]  = acc_sq[p] + SQ_W'(longint'(mag) * longint'(mag));
            acc_cnt[p] = acc_cnt[p] + 1'b1;
        end
        if (!it.last) return;
        // signed division truncates toward zero, as the offset wants
        mean_q     = longint'(acc_sum[p]) / longint'({1'b0, acc_cnt[p]});
        mean_sq    = longint'({1'b0, acc_sq[p]}) / longint'({1'b0, acc_cnt[p]});
        rep.ph     = it.ph;
        rep.rms    = floor_sqrt(mean_sq);
        rep.offs   = mean_q[SAMPLE_BITS-1:0];
        rep.p2p    = SAMPLE_BITS'(int'(acc_max[p]) - int'(acc_min[p]));
        rep.clips  = acc_clips[p];
        rep.ovf    = acc_ovf[p];
        expected_reports.push_back(rep);
        clear_phase_acc(p);
    endfunction

    function automatic void check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_v, got_v);
            err_count++;
        end
    endfunction

    // compare one accepted report against the oldest prediction
    function automatic void check_report();
        t_report exp_r;
        if (expected_reports.size() == 0) begin
            $display("%0t: unexpected report, expected none, actual phase %0d",
                     $time, out_phase);
            err_count++;
            return;
        end
        exp_r = expected_reports.pop_front();
        check_field("result_phase", exp_r.ph, out_phase);
        check_field("rms_value", exp_r.rms, out_rms);
        check_field("offset_value", exp_r.offs, out_offset);
        check_field("peak_to_peak", exp_r.p2p, out_p2p);
        check_field("clip_count", exp_r.clips, out_clips);
        check_field("overflow", exp_r.ovf, out_ovf);
    endfunction

    // ------------------------------------------------------------------------
    // clocked driver, receiver and monitor
    // ------------------------------------------------------------------------

    // sample driver: load a new item only when the slot is free or just taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_item = pending_samples.pop_front();
                in_valid  <= 1'b1;
                in_sample <= drv_item.smp;
                in_phase  <= drv_item.ph;
                in_last   <= drv_item.last;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // report receiver: random back-pressure
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // monitor: threshold writes, report checks and sample predictions all
    // use the values seen just before the edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_model = THR_RESET;
            for (int p = 0; p < PHASES; p++) clear_phase_acc(p);
        end else begin
            if (cfg_wr_en) thr_model = cfg_wr_data;
            if (out_valid && !out_stall) check_report();
            if (in_valid && !in_stall)
                meter_accept(t_sample_item'{smp: in_sample, ph: in_phase, last: in_last});
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic put_item(logic signed [SAMPLE_BITS-1:0] smp, logic [PHASE_W-1:0] ph,
                            logic last);
        t_sample_item it;
        it.smp  = smp;
        it.ph   = ph;
        it.last = last;
        pending_samples.push_back(it);
    endtask

    // wait until every item went in and every report came out, then let the
    // last non-reporting samples finish before anything else changes
    task automatic wait_idle();
        while (pending_samples.size() != 0 || in_valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // threshold write, only called with the block idle
    task automatic write_threshold(logic [THR_W-1:0] v);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        cur_thr = v;
        @(negedge i_clk);
    endtask

    // mix of rail values, values around the clip threshold and random values
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(logic [THR_W-1:0] thr);
        int k;
        int m;
        k = $urandom_range(99);
        if (k < 12) begin
            case ($urandom_range(4))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                3:       return -16'sd1;
                default: return 16'sd1;
            endcase
        end else if (k < 35) begin
            m = int'(thr) + int'($urandom_range(2)) - 1;
            if (m < 0) m = 0;
            if (m > 32768) m = 32768;
            if ($urandom_range(1)) m = -m;
            if (m > 32767) m = 32767;
            return SAMPLE_BITS'(m);
        end
        return SAMPLE_BITS'($urandom);
    endfunction

    // interleaved records of random length on random phases, with some
    // unused phase codes mixed in as noise
    task automatic queue_records(int n_items);
        int                 done;
        logic [PHASE_W-1:0] ph;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(99) < 8) ph = PH_UNUSED;
            else ph = PHASE_W'($urandom_range(PHASES - 1));
            put_item(pick_sample(cur_thr), ph, $urandom_range(5) == 0);
            if (ph != PH_UNUSED) done++;
        end
    endtask

    initial begin
        // reset once, at the start
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // sender idles a little, receiver a lot
        send_idle_pct = 9;
        recv_idle_pct = 74;

        // directed records at the reset threshold
        put_item(16'sh7FFF, 2'd0, 1'b1);                   // positive rail alone
        put_item(16'sh8000, 2'd1, 1'b1);                   // negative rail alone
        put_item(16'sh7FFF, 2'd2, 1'b0);                   // full swing
        put_item(16'sh8000, 2'd2, 1'b1);
        put_item(16'sd0, 2'd0, 1'b1);                      // all zero
        put_item(16'sd20794, 2'd1, 1'b0);                  // both sides of clip level
        put_item(-16'sd20794, 2'd1, 1'b0);
        put_item(16'sd20793, 2'd1, 1'b0);
        put_item(-16'sd20793, 2'd1, 1'b1);
        put_item(-16'sd3, 2'd0, 1'b0);                     // interleaved records
        put_item(16'sd5, 2'd1, 1'b0);
        put_item(16'sd77, PH_UNUSED, 1'b1);                // ignored phase code
        put_item(-16'sd4, 2'd0, 1'b1);                     // negative mean truncates
        put_item(16'sd6, 2'd1, 1'b1);
        put_item(-16'sd1, PH_UNUSED, 1'b0);
        put_item(-16'sd100, 2'd2, 1'b0);                   // min and max from first
        put_item(-16'sd50, 2'd2, 1'b0);
        put_item(-16'sd75, 2'd2, 1'b1);
        put_item(16'sd100, 2'd0, 1'b0);
        put_item(16'sd50, 2'd0, 1'b1);
        put_item(16'sh5555, 2'd1, 1'b0);
        put_item(16'shAAAA, 2'd1, 1'b1);
        wait_idle();

        // every sample clips
        write_threshold(16'd0);
        queue_records(130);
        wait_idle();

        // only the negative rail clips; sender idles a lot, receiver a little
        send_idle_pct = 74;
        recv_idle_pct = 9;
        write_threshold(16'd32768);
        queue_records(130);
        wait_idle();

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(16'd32767);
        queue_records(65);
        wait_idle();
        write_threshold(THR_W'($urandom_range(1, 32766)));
        queue_records(65);
        // close whatever records are still open
        for (int p = 0; p < PHASES; p++) put_item(pick_sample(cur_thr), PHASE_W'(p), 1'b1);
        wait_idle();

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/wrms_pkg.sv
hw/rtl/wrms_acc_mem.sv
hw/rtl/wrms_div.sv
hw/rtl/wrms_sqrt.sv
hw/rtl/waveform_rms_offset_peak_stats_core.sv
hw/rtl/wrms_checker.sv
dv/tb_waveform_rms_offset_peak_stats_core.sv
